// ----- rtl/core/pcds_pkg.sv -----
// Shared types, constants and helper functions for the PLL divider search.
package pcds_pkg;

   localparam int FreqW         = 18;
   localparam int NumW          = 7;
   localparam int DivW          = 6;
   localparam int FW            = 22;   // target * 10

   localparam logic [FreqW-1:0] MIN_FREQ     = 18'd8000;
   localparam logic [FreqW-1:0] MAX_FREQ_RST = 18'd85500;

   localparam int REF_KHZ_X10   = 143181;
   localparam int REF_KHZ       = 14318;
   localparam int NUM_LO        = 32;
   localparam int NUM_END       = 128;
   localparam int DIV_MIN       = 7;
   localparam int DIV_MAX       = 63;
   localparam int DIV_SMALL_MAX = 31;
   localparam int LANES         = NUM_END - NUM_LO;
   localparam int LEAVES        = 128;

   typedef struct packed {
      logic             ok;
      logic [FreqW-1:0] diff;
      logic [FreqW-1:0] freq;
      logic [NumW-1:0]  num;
      logic [DivW-1:0]  div;
   } cand_type;

   typedef struct packed {
      logic ge;
      logic enc;
      logic look;
      logic dif;
      logic sel;
   } lane_en_type;

   typedef struct packed {
      logic l2;
      logic l4;
      logic l6;
      logic l7;
   } tree_en_type;

   // valid b wins over invalid a or if strictly closer, so ties keep earlier a
   function automatic cand_type pick(input cand_type a, input cand_type b);
      return (b.ok && (!a.ok || (b.diff < a.diff))) ? b : a;
   endfunction

   function automatic logic [DivW-1:0] round_div(input logic [DivW-1:0] d);
      return (d > DivW'(DIV_SMALL_MAX)) ? {d[DivW-1:1], 1'b0} : d;
   endfunction

   function automatic logic [FreqW-1:0] abs_diff(input logic [FreqW-1:0] a,
                                                 input logic [FreqW-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ----- rtl/core/pcds_lane.sv -----
// One numerator lane: floor/ceil divisor from threshold compares, frequency lookup, local pick.
module pcds_lane import pcds_pkg::*; #(
   parameter int NUM = 32
) (
   input  logic             clock,
   input  lane_en_type      en,
   input  logic [FW-1:0]    f,
   input  logic [FreqW-1:0] target,
   output cand_type         cand
);

   localparam int PN  = REF_KHZ_X10 * NUM;
   localparam int KLO = DIV_MIN - 1;
   localparam int KHI = DIV_MAX + 1;
   localparam int NK  = KHI - KLO + 1;

   // thermometer: ge[i] means floor(PN / f) >= KLO + i
   logic [NK-1:0]    ge_in;
   logic [NK-1:0]    ge_ff;
   logic [NK-2:0]    eq_vec;
   logic             exact_in;
   logic             exact_ff;

   logic [DivW-1:0]  q;
   logic             inrange;
   logic             fok_in;
   logic             cok_in;
   logic [DivW-1:0]  cd_raw;
   logic [DivW-1:0]  fd_in;
   logic [DivW-1:0]  cd_in;
   logic [DivW-1:0]  fd_ff;
   logic [DivW-1:0]  cd_ff;
   logic             fok_ff;
   logic             cok_ff;

   logic [FreqW-1:0] htab [2**DivW];
   logic [FreqW-1:0] hf_ff;
   logic [FreqW-1:0] hc_ff;
   logic [DivW-1:0]  fd2_ff;
   logic [DivW-1:0]  cd2_ff;
   logic             fok2_ff;
   logic             cok2_ff;

   logic [FreqW-1:0] df_ff;
   logic [FreqW-1:0] dc_ff;
   logic [FreqW-1:0] hf3_ff;
   logic [FreqW-1:0] hc3_ff;
   logic [DivW-1:0]  fd3_ff;
   logic [DivW-1:0]  cd3_ff;
   logic             fok3_ff;
   logic             cok3_ff;

   cand_type         candf;
   cand_type         candc;
   cand_type         cand_ff;

   for (genvar i = 0; i < NK; i++) begin : g_thr
      localparam int K   = KLO + i;
      localparam int THR = PN / K;
      assign ge_in[i] = (f <= FW'(THR));
   end

   // f divides PN exactly: ceiling equals floor
   for (genvar i = 0; i < NK - 1; i++) begin : g_eq
      localparam int K = KLO + i;
      if ((PN % K) == 0) begin : g_div
         localparam int QV = PN / K;
         assign eq_vec[i] = (f == FW'(QV));
      end else begin : g_nodiv
         assign eq_vec[i] = 1'b0;
      end
   end

   assign exact_in = |eq_vec;

   always_ff @(posedge clock) begin
      if (en.ge) begin
         ge_ff    <= ge_in;
         exact_ff <= exact_in;
      end
   end

   always_comb begin
      q = '0;
      for (int i = 0; i < NK - 1; i++) begin
         if (ge_ff[i] && !ge_ff[i+1]) begin
            q = q | DivW'(KLO + i);
         end
      end
   end

   assign inrange = ge_ff[0] & ~ge_ff[NK-1];
   assign fok_in  = inrange & (q != DivW'(KLO));
   assign cok_in  = exact_ff ? fok_in : (inrange & (q != DivW'(DIV_MAX)));
   assign cd_raw  = exact_ff ? q : (q + DivW'(1));
   assign fd_in   = round_div(q);
   assign cd_in   = round_div(cd_raw);

   always_ff @(posedge clock) begin
      if (en.enc) begin
         fd_ff  <= fd_in;
         cd_ff  <= cd_in;
         fok_ff <= fok_in;
         cok_ff <= cok_in;
      end
   end

   // achieved frequency per divisor for this numerator
   for (genvar d = 0; d < 2**DivW; d++) begin : g_htab
      if (d < DIV_MIN) begin : g_zero
         assign htab[d] = '0;
      end else begin : g_val
         localparam int H = (REF_KHZ * NUM) / d;
         assign htab[d] = FreqW'(H);
      end
   end

   always_ff @(posedge clock) begin
      if (en.look) begin
         hf_ff   <= htab[fd_ff];
         hc_ff   <= htab[cd_ff];
         fd2_ff  <= fd_ff;
         cd2_ff  <= cd_ff;
         fok2_ff <= fok_ff;
         cok2_ff <= cok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en.dif) begin
         df_ff   <= abs_diff(hf_ff, target);
         dc_ff   <= abs_diff(hc_ff, target);
         hf3_ff  <= hf_ff;
         hc3_ff  <= hc_ff;
         fd3_ff  <= fd2_ff;
         cd3_ff  <= cd2_ff;
         fok3_ff <= fok2_ff;
         cok3_ff <= cok2_ff;
      end
   end

   assign candf = '{ok: fok3_ff, diff: df_ff, freq: hf3_ff, num: NumW'(NUM), div: fd3_ff};
   assign candc = '{ok: cok3_ff, diff: dc_ff, freq: hc3_ff, num: NumW'(NUM), div: cd3_ff};

   always_ff @(posedge clock) begin
      if (en.sel) begin
         cand_ff <= pick(candf, candc);
      end
   end

   assign cand = cand_ff;

endmodule

// ----- rtl/core/pcds_tree.sv -----
// Registered selection tree over all candidates, two levels per stage but one in the last.
module pcds_tree import pcds_pkg::*; (
   input  logic        clock,
   input  tree_en_type en,
   input  cand_type    leaf [LEAVES],
   output cand_type    win
);

   localparam int N1 = LEAVES / 2;
   localparam int N2 = LEAVES / 4;
   localparam int N3 = LEAVES / 8;
   localparam int N4 = LEAVES / 16;
   localparam int N5 = LEAVES / 32;
   localparam int N6 = LEAVES / 64;

   cand_type l1c   [N1];
   cand_type l2_ff [N2];
   cand_type l3c   [N3];
   cand_type l4_ff [N4];
   cand_type l5c   [N5];
   cand_type l6_ff [N6];
   cand_type l7_ff;

   always_comb begin
      for (int i = 0; i < N1; i++) begin
         l1c[i] = pick(leaf[2*i], leaf[2*i+1]);
      end
      for (int i = 0; i < N3; i++) begin
         l3c[i] = pick(l2_ff[2*i], l2_ff[2*i+1]);
      end
      for (int i = 0; i < N5; i++) begin
         l5c[i] = pick(l4_ff[2*i], l4_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.l2) begin
         for (int i = 0; i < N2; i++) begin
            l2_ff[i] <= pick(l1c[2*i], l1c[2*i+1]);
         end
      end
      if (en.l4) begin
         for (int i = 0; i < N4; i++) begin
            l4_ff[i] <= pick(l3c[2*i], l3c[2*i+1]);
         end
      end
      if (en.l6) begin
         for (int i = 0; i < N6; i++) begin
            l6_ff[i] <= pick(l5c[2*i], l5c[2*i+1]);
         end
      end
      if (en.l7) begin
         l7_ff <= pick(l6_ff[0], l6_ff[1]);
      end
   end

   assign win = l7_ff;

endmodule

// ----- rtl/core/pll_clock_divider_search.sv -----
// Top level of the PLL divider search pipeline.
// Takes one requested pixel clock per cycle and returns the closest achievable
// 14.318 MHz PLL setting through clamp, scale, threshold compares in 96 parallel
// numerator lanes, divisor encode, frequency lookup, error compute, per-lane
// pick, then a four-stage selection tree whose last stage is the output
// register. Each stage stalls only when the one after it is full, so throughput
// is one transaction per cycle while rsp_ready stays high. max_freq resets to
// 85500 kHz; users write it through csr only when idle, which is not enforced.
module pll_clock_divider_search import pcds_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [FreqW-1:0] csr_max_freq,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [FreqW-1:0] req_freq,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [FreqW-1:0] rsp_best_freq,
   output logic [NumW-1:0]  rsp_numerator,
   output logic [4:0]       rsp_denominator,
   output logic             rsp_post_divide
);

   localparam int NST = 11;

   logic [FreqW-1:0] max_ff;
   logic [NST:1]     v_ff;
   logic [NST:1]     en;

   logic [FreqW-1:0] lo_clamp;
   logic [FreqW-1:0] tgt_in;
   logic [FreqW-1:0] tgt_ff [6];
   logic [FW-1:0]    f_ff;

   cand_type         leaf [LEAVES];
   cand_type         leaf0_ff;
   cand_type         win;
   lane_en_type      lane_en;
   tree_en_type      tree_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_FREQ_RST;
      end else if (csr_valid) begin
         max_ff <= csr_max_freq;
      end
   end

   assign csr_ready = 1'b1;

   // a stage loads when empty or when the next one moves
   always_comb begin
      en[NST] = ~v_ff[NST] | rsp_ready;
      for (int k = NST - 1; k >= 1; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) begin
            v_ff[1] <= req_valid;
         end
         for (int k = 2; k <= NST; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign req_ready = en[1];
   assign rsp_valid = v_ff[NST];

   // low clamp first, then the configured ceiling
   assign lo_clamp = (req_freq < MIN_FREQ) ? MIN_FREQ : req_freq;
   assign tgt_in   = (lo_clamp > max_ff) ? max_ff : lo_clamp;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         tgt_ff[0] <= tgt_in;
      end
      if (en[2]) begin
         f_ff <= (FW'(tgt_ff[0]) << 3) + (FW'(tgt_ff[0]) << 1);
      end
      for (int k = 1; k < 6; k++) begin
         if (en[k+1]) begin
            tgt_ff[k] <= tgt_ff[k-1];
         end
      end
   end

   assign lane_en = '{ge: en[3], enc: en[4], look: en[5], dif: en[6], sel: en[7]};
   assign tree_en = '{l2: en[8], l4: en[9], l6: en[10], l7: en[11]};

   // the zero-frequency default sits first, so a candidate must beat it strictly
   always_ff @(posedge clock) begin
      if (en[7]) begin
         leaf0_ff <= '{ok: 1'b1, diff: tgt_ff[5], freq: '0, num: '0, div: '0};
      end
   end

   assign leaf[0] = leaf0_ff;

   for (genvar n = NUM_LO; n < NUM_END; n++) begin : g_lane
      pcds_lane #(
         .NUM (n)
      ) u_lane (
         .clock  (clock),
         .en     (lane_en),
         .f      (f_ff),
         .target (tgt_ff[4]),
         .cand   (leaf[n - NUM_LO + 1])
      );
   end

   for (genvar i = LANES + 1; i < LEAVES; i++) begin : g_pad
      assign leaf[i] = '{ok: 1'b0, diff: '0, freq: '0, num: '0, div: '0};
   end

   pcds_tree u_tree (
      .clock (clock),
      .en    (tree_en),
      .leaf  (leaf),
      .win   (win)
   );

   assign rsp_best_freq   = win.freq;
   assign rsp_numerator   = win.num;
   assign rsp_denominator = win.div[DivW-1] ? win.div[DivW-1:1] : win.div[4:0];
   assign rsp_post_divide = win.div[DivW-1];

   a_none_all_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_numerator == '0)) |->
         ((rsp_best_freq == '0) && (rsp_denominator == '0) && !rsp_post_divide))
      else $error("empty result carries nonzero fields");

   a_num_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_numerator != '0)) |-> (rsp_numerator >= NumW'(NUM_LO)))
      else $error("numerator below search range");

   a_post_den: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_post_divide) |-> (rsp_denominator >= 5'd16))
      else $error("post divide with small denominator");

   a_small_den: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_numerator != '0) && !rsp_post_divide) |->
         (rsp_denominator >= 5'(DIV_MIN)))
      else $error("divisor below minimum");

endmodule
